// ----- sv/lrut_pkg.sv -----
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared sizes, command and status codes and sequencer states of the
// recency-ordered timeout table.
// ----------------------------------------------------------------------------
package lrut_pkg;

   localparam int TableDepth = 32;
   localparam int SlotBits   = $clog2(TableDepth);
   localparam int CountBits  = $clog2(TableDepth + 1);
   localparam int KeyBits    = 64;
   localparam int TimeBits   = 32;
   localparam int CmdBits    = 3;
   localparam int StatusBits = 3;

   // command codes
   localparam logic [CmdBits-1:0] CMD_INSERT = 3'd0;
   localparam logic [CmdBits-1:0] CMD_FIND   = 3'd1;
   localparam logic [CmdBits-1:0] CMD_BUMP   = 3'd2;
   localparam logic [CmdBits-1:0] CMD_DELETE = 3'd3;
   localparam logic [CmdBits-1:0] CMD_EXPIRE = 3'd4;

   // status codes
   localparam logic [StatusBits-1:0] STAT_OK        = 3'd0;
   localparam logic [StatusBits-1:0] STAT_FULL      = 3'd1;
   localparam logic [StatusBits-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [StatusBits-1:0] STAT_EXPIRED   = 3'd3;
   localparam logic [StatusBits-1:0] STAT_NONE_AGED = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_LINK,
      ST_EXPIRE
   } state_type;

endpackage

// ----- sv/lru_timeout_table_unit.sv -----
// ----------------------------------------------------------------------------
// lru_timeout_table_unit
// Table of keyed entries kept as a doubly linked recency list in slot RAMs,
// with insert, find, bump, delete and timeout expiry scan.
//
//   channel | direction | handshake            | word
//   req     | in        | start / busy         | command, key, now_seconds
//   rsp     | out       | rsp_valid strobe     | status, key_out, slot, left, last
//   csr     | in        | csr_valid / ready    | timeout in seconds
//
// Insert and unknown commands are answered straight from idle. Find, bump and
// delete walk the list newest to oldest one slot per cycle through the key and
// link RAM read port; bump then relinks the matched slot at the newest end.
// Expiry walks from the oldest end one entry per cycle. Each result word is
// registered onto rsp and cannot be stalled.
// Synchronous reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_timeout_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lrut_pkg::CmdBits-1:0]      req_command,
   input  logic [lrut_pkg::KeyBits-1:0]      req_key,
   input  logic [lrut_pkg::TimeBits-1:0]     req_now_seconds,
   output logic                              rsp_valid,
   output logic [lrut_pkg::StatusBits-1:0]   rsp_status,
   output logic [lrut_pkg::KeyBits-1:0]      rsp_key_out,
   output logic [lrut_pkg::SlotBits-1:0]     rsp_slot,
   output logic [lrut_pkg::CountBits-1:0]    rsp_entries_left,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrut_pkg::TimeBits-1:0]     csr_wdata
);
   import lrut_pkg::*;

   state_type               state_ff, state_in;
   logic [CmdBits-1:0]      cmd_ff, cmd_in;
   logic [KeyBits-1:0]      key_ff, key_in;
   logic [TimeBits-1:0]     now_ff, now_in;
   logic [TimeBits-1:0]     timeout_ff;
   logic [TableDepth-1:0]   valid_ff, valid_in;
   logic [SlotBits-1:0]     newest_ff, newest_in;
   logic [SlotBits-1:0]     oldest_ff, oldest_in;
   logic [CountBits-1:0]    count_ff, count_in;
   logic [CountBits-1:0]    visit_ff, visit_in;
   logic [SlotBits-1:0]     cur_ff;

   logic                    pend_valid_ff, pend_valid_in;
   logic [KeyBits-1:0]      pend_key_ff, pend_key_in;
   logic [SlotBits-1:0]     pend_slot_ff, pend_slot_in;
   logic [CountBits-1:0]    pend_count_ff, pend_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [StatusBits-1:0]   rsp_status_ff, rsp_status_in;
   logic [KeyBits-1:0]      rsp_key_ff, rsp_key_in;
   logic [SlotBits-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [CountBits-1:0]    rsp_left_ff, rsp_left_in;
   logic                    rsp_last_ff, rsp_last_in;

   // RAM ports
   logic [SlotBits-1:0]     rd_addr;
   logic [KeyBits-1:0]      rd_key;
   logic [TimeBits-1:0]     rd_stamp;
   logic [SlotBits-1:0]     rd_newer;
   logic [SlotBits-1:0]     rd_older;
   logic                    key_we, stamp_we, nl_we, ol_we;
   logic [SlotBits-1:0]     key_wa, stamp_wa, nl_wa, ol_wa;
   logic [KeyBits-1:0]      key_wd;
   logic [TimeBits-1:0]     stamp_wd;
   logic [SlotBits-1:0]     nl_wd, ol_wd;

   logic [SlotBits-1:0]     free_slot;
   logic                    accept;
   logic                    expired;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign expired   = (count_ff != '0) && ((now_ff - rd_stamp) >= timeout_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_entries_left = rsp_left_ff;
   assign rsp_last         = rsp_last_ff;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SlotBits'(i);
         end
      end
   end

   // slot RAMs
   lrut_ram #(.WIDTH(KeyBits), .DEPTH(TableDepth)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(rd_addr), .rd_data(rd_key)
   );
   lrut_ram #(.WIDTH(TimeBits), .DEPTH(TableDepth)) u_stamp_ram (
      .clock(clock), .wr_en(stamp_we), .wr_addr(stamp_wa), .wr_data(stamp_wd),
      .rd_addr(rd_addr), .rd_data(rd_stamp)
   );
   lrut_ram #(.WIDTH(SlotBits), .DEPTH(TableDepth)) u_newer_ram (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
      .rd_addr(rd_addr), .rd_data(rd_newer)
   );
   lrut_ram #(.WIDTH(SlotBits), .DEPTH(TableDepth)) u_older_ram (
      .clock(clock), .wr_en(ol_we), .wr_addr(ol_wa), .wr_data(ol_wd),
      .rd_addr(rd_addr), .rd_data(rd_older)
   );

   // sequencer: next state, table updates and result words
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      valid_in      = valid_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      visit_in      = visit_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_slot_in  = pend_slot_ff;
      pend_count_in = pend_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_key_in    = '0;
      rsp_slot_in   = '0;
      rsp_left_in   = count_ff;
      rsp_last_in   = 1'b1;
      rd_addr       = '0;
      key_we   = 1'b0; key_wa   = free_slot; key_wd   = req_key;
      stamp_we = 1'b0; stamp_wa = free_slot; stamp_wd = req_now_seconds;
      nl_we    = 1'b0; nl_wa    = newest_ff; nl_wd    = free_slot;
      ol_we    = 1'b0; ol_wa    = free_slot; ol_wd    = newest_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_command == CMD_EXPIRE) ? oldest_ff : newest_ff;
            if (accept) begin
               cmd_in   = req_command;
               key_in   = req_key;
               now_in   = req_now_seconds;
               visit_in = '0;
               case (req_command) inside
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff[CountBits-1]) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        key_we   = 1'b1;
                        stamp_we = 1'b1;
                        if (count_ff == '0) begin
                           oldest_in = free_slot;
                        end else begin
                           nl_we = 1'b1;
                           ol_we = 1'b1;
                        end
                        newest_in           = free_slot;
                        valid_in[free_slot] = 1'b1;
                        count_in            = count_ff + 1'b1;
                        rsp_slot_in         = free_slot;
                        rsp_left_in         = count_ff + 1'b1;
                     end
                  end
                  CMD_FIND, CMD_BUMP, CMD_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_EXPIRE: begin
                     pend_valid_in = 1'b0;
                     state_in      = ST_EXPIRE;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NOT_FOUND;
                  end
               endcase
            end
         end

         ST_WALK: begin
            rd_addr = rd_older;
            if (rd_key == key_ff) begin
               rsp_key_in  = rd_key;
               rsp_slot_in = cur_ff;
               if (cmd_ff != CMD_FIND) begin
                  // drop the matched slot from the list
                  valid_in[cur_ff] = 1'b0;
                  if (count_ff <= CountBits'(1)) begin
                     count_in = '0;
                  end else begin
                     if (cur_ff == newest_ff) begin
                        newest_in = rd_older;
                     end else if (cur_ff == oldest_ff) begin
                        oldest_in = rd_newer;
                     end else begin
                        nl_we = 1'b1; nl_wa = rd_older; nl_wd = rd_newer;
                        ol_we = 1'b1; ol_wa = rd_newer; ol_wd = rd_older;
                     end
                     count_in = count_ff - 1'b1;
                  end
               end
               rsp_left_in = count_in;
               if (cmd_ff == CMD_BUMP) begin
                  // hold the matched slot for the relink
                  rd_addr  = cur_ff;
                  state_in = ST_LINK;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if ((visit_ff + 1'b1) == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               state_in      = ST_IDLE;
            end else begin
               visit_in = visit_ff + 1'b1;
            end
         end

         ST_LINK: begin
            // relink the bumped slot at the newest end and restamp it
            stamp_we = 1'b1; stamp_wa = cur_ff; stamp_wd = now_ff;
            if (count_ff == '0) begin
               oldest_in = cur_ff;
            end else begin
               nl_we = 1'b1; nl_wa = newest_ff; nl_wd = cur_ff;
               ol_we = 1'b1; ol_wa = cur_ff;    ol_wd = newest_ff;
            end
            rd_addr          = cur_ff;
            newest_in        = cur_ff;
            valid_in[cur_ff] = 1'b1;
            count_in         = count_ff + 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_key_in       = key_ff;
            rsp_slot_in      = cur_ff;
            rsp_left_in      = count_ff + 1'b1;
            state_in         = ST_IDLE;
         end

         ST_EXPIRE: begin
            rd_addr = rd_newer;
            if (expired) begin
               // remove the oldest entry, release the held word as not last
               valid_in[cur_ff] = 1'b0;
               if (count_ff <= CountBits'(1)) begin
                  count_in = '0;
               end else begin
                  oldest_in = rd_newer;
                  count_in  = count_ff - 1'b1;
               end
               rsp_valid_in  = pend_valid_ff;
               rsp_status_in = STAT_EXPIRED;
               rsp_key_in    = pend_key_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_left_in   = pend_count_ff;
               rsp_last_in   = 1'b0;
               pend_valid_in = 1'b1;
               pend_key_in   = rd_key;
               pend_slot_in  = cur_ff;
               pend_count_in = count_in;
            end else begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_in = STAT_EXPIRED;
                  rsp_key_in    = pend_key_ff;
                  rsp_slot_in   = pend_slot_ff;
                  rsp_left_in   = pend_count_ff;
               end else begin
                  rsp_status_in = STAT_NONE_AGED;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         newest_ff     <= '0;
         oldest_ff     <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         timeout_ff    <= TimeBits'(60);
      end else begin
         valid_ff      <= valid_in;
         newest_ff     <= newest_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      visit_ff      <= visit_in;
      cur_ff        <= rd_addr;
      pend_key_ff   <= pend_key_in;
      pend_slot_ff  <= pend_slot_in;
      pend_count_ff <= pend_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ----- sv/lrut_ram.sv -----
// ----------------------------------------------------------------------------
// lrut_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lrut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- tb/lru_timeout_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// lru_timeout_table_unit_tb
// Self-checking bench for the recency-ordered timeout table. A behavioral
// copy of the table (slot arrays, recency links, timeout) predicts every
// response word. Directed tests cover empty, full, extreme keys and times,
// unknown commands and timeout extremes. A random phase runs flow-like
// traffic over a small key pool under several timeouts, with bursty issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_timeout_table_unit_tb;
   import lrut_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 48;

   typedef struct packed {
      logic [StatusBits-1:0] status;
      logic [KeyBits-1:0]    key_out;
      logic [SlotBits-1:0]   slot;
      logic [CountBits-1:0]  left;
      logic                  last;
   } table_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CmdBits-1:0]    req_command;
   logic [KeyBits-1:0]    req_key;
   logic [TimeBits-1:0]   req_now_seconds;
   logic                  rsp_valid;
   logic [StatusBits-1:0] rsp_status;
   logic [KeyBits-1:0]    rsp_key_out;
   logic [SlotBits-1:0]   rsp_slot;
   logic [CountBits-1:0]  rsp_entries_left;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [TimeBits-1:0]   csr_wdata;

   lru_timeout_table_unit dut (.*);

   // shadow table
   logic [KeyBits-1:0]   slot_key   [TableDepth];
   logic [TimeBits-1:0]  slot_stamp [TableDepth];
   int                   link_newer [TableDepth];
   int                   link_older [TableDepth];
   logic [TableDepth-1:0] slot_used;
   int                   head_newest;
   int                   tail_oldest;
   int                   live_entries;
   logic [TimeBits-1:0]  timeout_sec;

   table_rsp_type        due_rsp [$];
   logic [KeyBits-1:0]   key_pool [$];
   logic [TimeBits-1:0]  clock_now;
   int                   fail_count;
   int                   rsp_seen;
   int                   expired_seen;
   int                   cycle_count;
   int                   burst_left;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic table_rsp_type make_rsp(logic [StatusBits-1:0] st,
                                              logic [KeyBits-1:0] k, int s, logic l);
      table_rsp_type r;
      r.status  = st;
      r.key_out = k;
      r.slot    = s[SlotBits-1:0];
      r.left    = live_entries[CountBits-1:0];
      r.last    = l;
      return r;
   endfunction

   task automatic unlink_entry(input int s);
      if (live_entries <= 1) begin
         live_entries = 0;
      end else begin
         if (s == head_newest) begin
            head_newest = link_older[s];
         end else if (s == tail_oldest) begin
            tail_oldest = link_newer[s];
         end else begin
            link_newer[link_older[s]] = link_newer[s];
            link_older[link_newer[s]] = link_older[s];
         end
         live_entries--;
      end
      slot_used[s] = 1'b0;
   endtask

   task automatic link_entry(input int s, input logic [TimeBits-1:0] now);
      if (live_entries == 0) begin
         tail_oldest = s;
      end else begin
         link_newer[head_newest] = s;
         link_older[s] = head_newest;
      end
      head_newest   = s;
      slot_stamp[s] = now;
      slot_used[s]  = 1'b1;
      live_entries++;
   endtask

   // work out the response words of one accepted command
   task automatic predict_table_cmd(input logic [CmdBits-1:0] cmd,
                                    input logic [KeyBits-1:0] k,
                                    input logic [TimeBits-1:0] now);
      int s;
      int cur;
      logic [TimeBits-1:0] age;
      table_rsp_type batch [$];
      case (cmd)
         CMD_INSERT: begin
            if (live_entries >= TableDepth) begin
               batch.push_back(make_rsp(STAT_FULL, '0, 0, 1'b1));
            end else begin
               s = 0;
               while (slot_used[s]) s++;
               slot_key[s] = k;
               link_entry(s, now);
               batch.push_back(make_rsp(STAT_OK, '0, s, 1'b1));
            end
         end
         CMD_FIND, CMD_BUMP, CMD_DELETE: begin
            s = TableDepth;
            cur = head_newest;
            for (int i = 0; i < live_entries; i++) begin
               if (slot_key[cur] == k) begin
                  s = cur;
                  break;
               end
               cur = link_older[cur];
            end
            if (s == TableDepth) begin
               batch.push_back(make_rsp(STAT_NOT_FOUND, '0, 0, 1'b1));
            end else begin
               if (cmd == CMD_BUMP) begin
                  unlink_entry(s);
                  link_entry(s, now);
               end else if (cmd == CMD_DELETE) begin
                  unlink_entry(s);
               end
               batch.push_back(make_rsp(STAT_OK, slot_key[s], s, 1'b1));
            end
         end
         CMD_EXPIRE: begin
            while (live_entries > 0 && batch.size() < TableDepth) begin
               s = tail_oldest;
               age = now - slot_stamp[s];
               if (age < timeout_sec) break;
               unlink_entry(s);
               batch.push_back(make_rsp(STAT_EXPIRED, slot_key[s], s, 1'b0));
            end
            if (batch.size() == 0)
               batch.push_back(make_rsp(STAT_NONE_AGED, '0, 0, 1'b1));
            else
               batch[batch.size()-1].last = 1'b1;
         end
         default: begin
            batch.push_back(make_rsp(STAT_NOT_FOUND, '0, 0, 1'b1));
         end
      endcase
      foreach (batch[i]) due_rsp.push_back(batch[i]);
   endtask

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      table_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (rsp_status == STAT_EXPIRED) expired_seen++;
         if (due_rsp.size() == 0) begin
            $display("%0t unexpected word: status %0d key %h slot %0d left %0d last %0d",
                     $time, rsp_status, rsp_key_out, rsp_slot, rsp_entries_left, rsp_last);
            fail_count++;
         end else begin
            exp_rsp = due_rsp.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t status: expected %0d actual %0d", $time, exp_rsp.status,
                        rsp_status);
               fail_count++;
            end
            if (rsp_key_out !== exp_rsp.key_out) begin
               $display("%0t key_out: expected %h actual %h", $time, exp_rsp.key_out,
                        rsp_key_out);
               fail_count++;
            end
            if (rsp_slot !== exp_rsp.slot) begin
               $display("%0t slot: expected %0d actual %0d", $time, exp_rsp.slot, rsp_slot);
               fail_count++;
            end
            if (rsp_entries_left !== exp_rsp.left) begin
               $display("%0t entries_left: expected %0d actual %0d", $time, exp_rsp.left,
                        rsp_entries_left);
               fail_count++;
            end
            if (rsp_last !== exp_rsp.last) begin
               $display("%0t last: expected %0d actual %0d", $time, exp_rsp.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // issue one command word and hold it until accepted
   task automatic send_cmd(input logic [CmdBits-1:0] cmd, input logic [KeyBits-1:0] k,
                           input logic [TimeBits-1:0] now);
      start           <= 1'b1;
      req_command     <= cmd;
      req_key         <= k;
      req_now_seconds <= now;
      do @(posedge clock); while (busy);
      predict_table_cmd(cmd, k, now);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // let every predicted word arrive, then let the walk settle
   task automatic drain_table;
      start <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TimeBits-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      timeout_sec = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KeyBits-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // empty table, key extremes, each command, duplicates, unknown codes
   task automatic test_basic_commands;
      send_cmd(CMD_FIND, 64'h0, 32'd0);
      send_cmd(CMD_BUMP, '1, 32'd0);
      send_cmd(CMD_DELETE, 64'h5, 32'd0);
      send_cmd(CMD_EXPIRE, '0, 32'd1000);
      send_cmd(CMD_INSERT, 64'h0, 32'd0);
      send_cmd(CMD_INSERT, '1, '1);
      send_cmd(CMD_INSERT, 64'h0, 32'd7);
      send_cmd(CMD_FIND, 64'h0, 32'd8);
      send_cmd(CMD_FIND, '1, 32'd8);
      send_cmd(CMD_BUMP, 64'h0, 32'd9);
      send_cmd(CMD_DELETE, '1, 32'd9);
      send_cmd(CMD_FIND, '1, 32'd9);
      send_cmd(3'd5, 64'hA5A5_5A5A_F00F_0FF0, '1);
      send_cmd(3'd6, '0, '0);
      send_cmd(3'd7, '1, 32'h8000_0000);
      send_cmd(CMD_EXPIRE, '0, 32'd20);
      send_cmd(CMD_EXPIRE, '0, 32'd80);
      drain_table();
   endtask

   // fill every slot, overflow, then empty with a zero timeout
   task automatic test_full_table;
      for (int i = 0; i <= TableDepth; i++)
         send_cmd(CMD_INSERT, random_key(), 32'd100 + i);
      send_cmd(CMD_FIND, slot_key[tail_oldest], 32'd200);
      send_cmd(CMD_BUMP, slot_key[tail_oldest], 32'd200);
      send_cmd(CMD_DELETE, slot_key[7], 32'd200);
      send_cmd(CMD_INSERT, 64'h1234, 32'd201);
      drain_table();
      write_timeout(32'd0);
      send_cmd(CMD_EXPIRE, '0, 32'd0);
      drain_table();
   endtask

   // widest timeout and age wrap around zero
   task automatic test_timeout_extremes;
      write_timeout('1);
      send_cmd(CMD_INSERT, 64'h77, 32'd10);
      send_cmd(CMD_INSERT, 64'h78, 32'd11);
      send_cmd(CMD_EXPIRE, '0, 32'd8);
      send_cmd(CMD_EXPIRE, '0, 32'd9);
      drain_table();
      write_timeout(32'd1);
      send_cmd(CMD_INSERT, 64'h79, 32'hFFFF_FFFF);
      send_cmd(CMD_EXPIRE, '0, 32'hFFFF_FFFF);
      send_cmd(CMD_EXPIRE, '0, 32'd0);
      drain_table();
   endtask

   // flow-like traffic: mostly known keys and advancing time, some noise
   task automatic test_random_traffic(input int items, input logic [TimeBits-1:0] tmo);
      int pick;
      logic [KeyBits-1:0] k;
      logic [CmdBits-1:0] cmd;
      write_timeout(tmo);
      for (int n = 0; n < items; n++) begin
         clock_now = clock_now + $urandom_range(0, 12);
         if ($urandom_range(0, 49) == 0) clock_now = $urandom;
         if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
            k = random_key();
            key_pool.push_back(k);
            if (key_pool.size() > 20) key_pool.delete(0);
         end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) cmd = CMD_INSERT;
         else if (pick < 50) cmd = CMD_FIND;
         else if (pick < 65) cmd = CMD_BUMP;
         else if (pick < 78) cmd = CMD_DELETE;
         else if (pick < 95) cmd = CMD_EXPIRE;
         else cmd = CmdBits'($urandom_range(0, 7));
         send_cmd(cmd, k, clock_now);
         if (--burst_left <= 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 14);
         end
      end
      drain_table();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_INSERT;
      req_key = '0;
      req_now_seconds = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      cycle_count = 0;
      fail_count = 0;
      rsp_seen = 0;
      expired_seen = 0;
      burst_left = 4;
      clock_now = 32'hFFFF_FF00;
      slot_used = '0;
      head_newest = 0;
      tail_oldest = 0;
      live_entries = 0;
      timeout_sec = 32'd60;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      test_full_table();
      test_timeout_extremes();
      test_random_traffic(45, 32'd40);
      test_random_traffic(45, 32'd15);
      test_random_traffic(40, 32'd90);
      test_random_traffic(38, 32'd60);

      drain_table();
      $display("covered all commands, full and empty table, timeouts 0/1/max and random mix");
      $display("%0d response words checked, %0d expirations", rsp_seen, expired_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- lru_timeout_table_unit.f -----
sv/lrut_pkg.sv
sv/lrut_ram.sv
sv/lru_timeout_table_unit.sv
tb/lru_timeout_table_unit_tb.sv
